// File: src/bsp_pkg.sv
// ---------------------------------------------------------------------------
// bsp_pkg: shared definitions for the bit stream packer
// Operation and status codes, limits and port widths of the packer.
// ---------------------------------------------------------------------------
package bsp_pkg;

  // packet and raw field limits
  localparam int unsigned MaxPacketBytes = 8192;
  localparam int unsigned MaxRawBits     = 32;
  localparam int unsigned RawBitsCap     = (MaxRawBits < 32) ? MaxRawBits : 32;

  // register and field widths
  localparam int unsigned CapW       = 14;
  localparam int unsigned PosW       = 17;
  localparam int unsigned InDataW    = 72;
  localparam int unsigned InUserW    = 3;
  localparam int unsigned OutDataW   = 32;
  localparam int unsigned CapResetVal = 1024;

  // operation codes
  typedef enum logic [2:0] {
    OP_RAW      = 3'd0,
    OP_BND_CHK  = 3'd1,
    OP_BND_WRAP = 3'd2,
    OP_VARINT   = 3'd3,
    OP_END      = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ROOM  = 2'd1,
    ST_LIMIT = 2'd2
  } status_e;

endpackage

// File: src/bit_stream_packer.sv
// ---------------------------------------------------------------------------
// bit_stream_packer: LSB-first bit writer with packed ints
// Packs raw bits, bounded ints, 7-bit group ints and end markers into bytes.
// ---------------------------------------------------------------------------
// An item goes through an input register, is packed combinationally against
// the stream state and lands in a result register holding up to five completed
// bytes. The result port moves one request per cycle while m_axis_tready is
// high: an item that completes k bytes gives max(1, k) results (five at most,
// for a packed int), and a new item is taken every cycle while items give a
// single result each and the result port is not stalled. Capacity writes
// are taken at any time; write them only while the block is idle.
module bit_stream_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // capacity register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsp_pkg::CapW-1:0]      cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // value [31:0], bit_count [37:32], value_limit [69:38], zero [71:70]
  input  logic [bsp_pkg::InDataW-1:0]   s_axis_tdata,
  // operation [2:0]
  input  logic [bsp_pkg::InUserW-1:0]   s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_byte [7:0], status [9:8], end_of_packet [10], bits_written [27:11],
  // zero [31:28]
  output logic [bsp_pkg::OutDataW-1:0]  m_axis_tdata,
  // byte_valid [0]
  output logic                          m_axis_tuser,
  // last_of_item
  output logic                          m_axis_tlast
);
  import bsp_pkg::*;

  // input register
  logic        in_valid_q;
  logic [2:0]  op_q;
  logic [31:0] value_q;
  logic [5:0]  bc_q;
  logic [31:0] lim_q;

  // stream state and capacity
  logic [CapW-1:0] cap_q;
  logic [7:0]      part_q, part_d;
  logic [2:0]      pbc_q, pbc_d;
  logic [PosW-1:0] pos_q, pos_d;

  // result register
  logic            res_valid_q;
  logic [2:0]      rleft_q;
  logic [39:0]     rbytes_q;
  logic            rvld_q;
  logic [1:0]      rstat_q;
  logic            reop_q;
  logic [PosW-1:0] rpos_q;

  // packing datapath
  logic [CapW-1:0] cap_eff;
  logic [PosW-1:0] bit_limit, room;
  logic [5:0]      bc_sat;
  logic [31:0]     raw_bits;
  logic [31:0]     bnd_ok, lim_pow;
  logic [5:0]      bnd_n, bnd_need;
  logic [3:0]      more;
  logic [2:0]      grp_cnt;
  logic [39:0]     vi_bits;
  logic [39:0]     nb;
  logic [5:0]      nbits, need;
  logic            want, ended;
  status_e         status;
  logic [47:0]     acc;
  logic [5:0]      total;
  logic [2:0]      nbytes;
  logic [PosW-1:0] report_pos;

  // handshakes
  logic s_fire, m_fire, last_now, load;

  assign cfg_ready_o = 1'b1;
  assign s_fire   = s_axis_tvalid & s_axis_tready;
  assign m_fire   = res_valid_q & m_axis_tready;
  assign last_now = (rleft_q == 3'd1);
  assign load     = in_valid_q & (~res_valid_q | (m_fire & last_now));
  assign s_axis_tready = ~in_valid_q | load;

  // room left in the packet
  assign cap_eff   = (cap_q > CapW'(MaxPacketBytes)) ? CapW'(MaxPacketBytes) : cap_q;
  assign bit_limit = {cap_eff, 3'b000};
  assign room      = (pos_q >= bit_limit) ? '0 : bit_limit - pos_q;

  // raw bits, count saturated
  assign bc_sat = (bc_q > 6'(RawBitsCap)) ? 6'(RawBitsCap) : bc_q;
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      raw_bits[i] = value_q[i] & (6'(i) < bc_sat);
    end
  end

  // bounded int: bit i is written while prefix sum plus its weight stays below
  // the limit; the flags form a thermometer, so they also mask the value
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      bnd_ok[i]  = ((value_q & ((32'h1 << i) - 32'h1)) | (32'h1 << i)) < lim_q;
      lim_pow[i] = (32'h1 << i) < lim_q;
    end
  end
  assign bnd_n    = 6'($countones(bnd_ok));
  assign bnd_need = 6'($countones(lim_pow));

  // packed int groups, continuation flag in bit 0 of each byte
  assign more[0] = (value_q[31:7]  != '0);
  assign more[1] = (value_q[31:14] != '0);
  assign more[2] = (value_q[31:21] != '0);
  assign more[3] = (value_q[31:28] != '0);
  assign grp_cnt = 3'd1 + 3'($countones(more));
  assign vi_bits = {3'b000, value_q[31:28], 1'b0,
                    value_q[27:21], more[3],
                    value_q[20:14], more[2],
                    value_q[13:7],  more[1],
                    value_q[6:0],   more[0]};

  // operation decode, value and room checks
  always_comb begin
    nb     = '0;
    nbits  = '0;
    need   = '0;
    want   = 1'b0;
    ended  = 1'b0;
    status = ST_OK;
    case (op_q)
      OP_RAW: begin
        want  = 1'b1;
        need  = bc_sat;
        nbits = bc_sat;
        nb    = {8'h00, raw_bits};
      end
      OP_BND_CHK, OP_BND_WRAP: begin
        if ((op_q == OP_BND_CHK) && (value_q >= lim_q)) begin
          status = ST_LIMIT;
        end else begin
          want  = 1'b1;
          need  = bnd_need;
          nbits = bnd_n;
          nb    = {8'h00, value_q & bnd_ok};
        end
      end
      OP_VARINT: begin
        want  = 1'b1;
        need  = {grp_cnt, 3'b000};
        nbits = {grp_cnt, 3'b000};
        nb    = vi_bits;
      end
      OP_END: begin
        want  = 1'b1;
        need  = 6'd1;
        nbits = 6'd1;
        nb    = 40'h1;
        ended = 1'b1;
      end
      default: begin
        want = 1'b0;
      end
    endcase
    // room check, a rejected item writes nothing
    if (want && ({{(PosW-6){1'b0}}, need} > room)) begin
      status = ST_ROOM;
    end
    if (!want || (status != ST_OK)) begin
      nb    = '0;
      nbits = '0;
      ended = 1'b0;
    end
  end

  // merge new bits behind the partial byte
  assign acc        = {40'h0, part_q} | ({8'h00, nb} << pbc_q);
  assign total      = {3'b000, pbc_q} + nbits;
  assign nbytes     = ended ? 3'd1 : total[5:3];
  assign report_pos = pos_q + {{(PosW-6){1'b0}}, nbits};

  // next stream state
  always_comb begin
    if (ended) begin
      part_d = '0;
      pbc_d  = '0;
      pos_d  = '0;
    end else begin
      part_d = acc[{nbytes, 3'b000} +: 8];
      pbc_d  = total[2:0];
      pos_d  = report_pos;
    end
  end

  // control and stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      rleft_q     <= '0;
      cap_q       <= CapW'(CapResetVal);
      part_q      <= '0;
      pbc_q       <= '0;
      pos_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        res_valid_q <= 1'b1;
        rleft_q     <= (nbytes == 3'd0) ? 3'd1 : nbytes;
        part_q      <= part_d;
        pbc_q       <= pbc_d;
        pos_q       <= pos_d;
      end else if (m_fire) begin
        if (last_now) begin
          res_valid_q <= 1'b0;
        end
        rleft_q <= rleft_q - 3'd1;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q    <= s_axis_tuser;
      value_q <= s_axis_tdata[31:0];
      bc_q    <= s_axis_tdata[37:32];
      lim_q   <= s_axis_tdata[69:38];
    end
  end

  // result payload register, bytes shift out low first
  always_ff @(posedge clk_i) begin
    if (load) begin
      rbytes_q <= acc[39:0];
      rvld_q   <= (nbytes != 3'd0);
      rstat_q  <= status;
      reop_q   <= ended;
      rpos_q   <= report_pos;
    end else if (m_fire) begin
      rbytes_q <= {8'h00, rbytes_q[39:8]};
    end
  end

  // result port
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = rvld_q;
  assign m_axis_tlast  = last_now;
  assign m_axis_tdata  = {4'h0, rpos_q, reop_q & last_now, rstat_q,
                          rvld_q ? rbytes_q[7:0] : 8'h00};

  // bits above the partial count stay clear
  a_partial_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (part_q >> pbc_q) == 8'h00)
    else $error("partial byte holds bits beyond its count");

  // end of packet only on the final byte of an item
  a_eop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[10]) |-> (m_axis_tlast && m_axis_tuser))
    else $error("end of packet off the final byte");

  // a rejected item gives no byte
  a_reject_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[9:8] != ST_OK)) |-> (!m_axis_tuser && m_axis_tlast))
    else $error("rejected item produced a byte");

  // an accepted end marker restarts the packet
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ended) |=> (pos_q == '0 && pbc_q == 3'd0))
    else $error("packet not restarted after end marker");

endmodule
